// ----- rtl/hcb_pkg.sv -----
// ----------------------------------------------------------------------------
// hcb_pkg
// Shared codes, widths and control bundles of the Huffman code builder.
// ----------------------------------------------------------------------------
package hcb_pkg;

    localparam int DEF_SYMBOLS      = 256;
    localparam int DEF_COUNT_BITS   = 32;
    localparam int DEF_MAX_CODE_LEN = 64;

    localparam int REQ_W  = 3;
    localparam int STAT_W = 3;
    localparam int BYTE_W = 8;
    localparam int CODE_W = 64;
    localparam int LEN_W  = 7;

    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_COUNT  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_BUILD  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_ENCODE = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DECODE = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOT_BUILT = 3'd2;
    localparam logic [STAT_W-1:0] ST_NO_CODE   = 3'd3;
    localparam logic [STAT_W-1:0] ST_SINGLE    = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic clr_cnt;
        logic cnt_wr;
        logic b_init;
        logic leaf_step;
        logic chk;
        logic r_start;
        logic scan;
        logic merge;
        logic last_rd;
        logic move;
        logic root;
        logic w_rd;
        logic w_leaf;
        logic w_left;
        logic w_right;
        logic dec1;
        logic dec2;
        logic emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic tree_ready;
        logic root_leaf;
        logic leaf_last;
        logic none;
        logic one;
        logic scan_last;
        logic last_round;
        logic node_leaf;
        logic walk_last;
    } stat_t;

endpackage

// ----- rtl/huffman_code_builder.sv -----
// ----------------------------------------------------------------------------
// huffman_code_builder
// Byte-alphabet Huffman engine: count, build tree and codes, encode, decode.
// ----------------------------------------------------------------------------
//  channel | ports        | tdata (low bit up)                  | tuser
//  --------+--------------+-------------------------------------+-----------------------
//  request | s_t*         | data_byte[7:0], code_bit[8]         | req_type[2:0]
//  result  | m_t*         | code_bits[63:0], code_length[70:64],| status[2:0],
//          |              | symbol[78:71]                       | symbol_valid[3]
//
//  A clear or encode request goes from accept straight to the result state;
//  a count request first passes a count-write state, and a decode request
//  two decode states unless the tree is not built or is a single leaf. A
//  build sweeps the count memory one symbol per cycle, then each merge round
//  scans the working list one entry per cycle, then the code walk reads each
//  node, writing a leaf's code to the code table or the path codes of an
//  internal node's children. The working-list memory port sets the build time.
//  Reset clears counts (per-entry valid bits), code presence and tree state.
//  A waiting result is held in the output register; the sequencer stalls
//  only when it has a new result and the previous one was not transferred.
// ----------------------------------------------------------------------------
module huffman_code_builder import hcb_pkg::*; #(
    parameter int SYMBOLS      = DEF_SYMBOLS,
    parameter int COUNT_BITS   = DEF_COUNT_BITS,
    parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // data_byte[7:0], code_bit[8], zero pad
    input  logic [2:0]  s_tuser,   // req_type[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // code_bits[63:0], code_length[70:64], symbol[78:71]
    output logic [3:0]  m_tuser    // status[2:0], symbol_valid[3]
);

    cmd_t  cmd;
    stat_t stat;

    logic [STAT_W-1:0] status;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
    logic [BYTE_W-1:0] symbol;
    logic              symbol_valid;

    // sequencer: one request at a time
    hcb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .req_type (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // memories, build registers and the result register
    hcb_dpath #(
        .SYMBOLS      (SYMBOLS),
        .COUNT_BITS   (COUNT_BITS),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_req          (s_tuser),
        .s_byte         (s_tdata[7:0]),
        .s_bit          (s_tdata[8]),
        .m_status       (status),
        .m_code_bits    (code_bits),
        .m_code_length  (code_length),
        .m_symbol       (symbol),
        .m_symbol_valid (symbol_valid)
    );

    assign m_tdata = {1'b0, symbol, code_length, code_bits};
    assign m_tuser = {symbol_valid, status};

    // a decoded symbol only comes with an ok status
    a_sym_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[3] |-> m_tuser[2:0] == ST_OK)
        else $error("decoded symbol with error status");

    // code length never exceeds the configured limit
    a_len_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> 32'(m_tdata[70:64]) <= MAX_CODE_LEN)
        else $error("code length above limit");

    // a nonzero code length only on an ok result without a symbol
    a_len_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[70:64] != '0 |-> m_tuser[2:0] == ST_OK && !m_tuser[3])
        else $error("code length on a non-encode result");

endmodule

// ----- rtl/hcb_ctrl.sv -----
// ----------------------------------------------------------------------------
// hcb_ctrl
// Request sequencer: steps the datapath through each request type.
// ----------------------------------------------------------------------------
module hcb_ctrl import hcb_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [REQ_W-1:0] req_type,
    output logic             m_tvalid,
    input  logic             m_tready,
    output cmd_t             cmd,
    input  stat_t            stat
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_CNT    = 5'd1;
    localparam logic [4:0] S_FIN    = 5'd2;
    localparam logic [4:0] S_DEC1   = 5'd3;
    localparam logic [4:0] S_DEC2   = 5'd4;
    localparam logic [4:0] S_BINIT  = 5'd5;
    localparam logic [4:0] S_BLEAF  = 5'd6;
    localparam logic [4:0] S_BCHK   = 5'd7;
    localparam logic [4:0] S_BRST   = 5'd8;
    localparam logic [4:0] S_BSCAN  = 5'd9;
    localparam logic [4:0] S_BMERGE = 5'd10;
    localparam logic [4:0] S_BLRD   = 5'd11;
    localparam logic [4:0] S_BMOVE  = 5'd12;
    localparam logic [4:0] S_BROOT  = 5'd13;
    localparam logic [4:0] S_WRD    = 5'd14;
    localparam logic [4:0] S_WALK   = 5'd15;
    localparam logic [4:0] S_WRIGHT = 5'd16;

    logic [4:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_tready;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    unique case (req_type)
                        REQ_CLEAR: begin
                            cmd.clr_cnt = 1'b1;
                            state_next  = S_FIN;
                        end
                        REQ_COUNT:  state_next = S_CNT;
                        REQ_BUILD:  state_next = S_BINIT;
                        REQ_ENCODE: state_next = S_FIN;
                        REQ_DECODE: state_next = (stat.tree_ready && !stat.root_leaf)
                                                 ? S_DEC1 : S_FIN;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_CNT: begin
                cmd.cnt_wr = 1'b1;
                state_next = S_FIN;
            end
            S_DEC1: begin
                cmd.dec1   = 1'b1;
                state_next = S_DEC2;
            end
            S_DEC2: begin
                cmd.dec2   = 1'b1;
                state_next = S_FIN;
            end
            S_FIN: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.emit     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_BINIT: begin
                cmd.b_init = 1'b1;
                state_next = S_BLEAF;
            end
            S_BLEAF: begin
                cmd.leaf_step = 1'b1;
                if (stat.leaf_last) state_next = S_BCHK;
            end
            S_BCHK: begin
                cmd.chk = 1'b1;
                if (stat.none)     state_next = S_FIN;
                else if (stat.one) state_next = S_BROOT;
                else               state_next = S_BRST;
            end
            S_BRST: begin
                cmd.r_start = 1'b1;
                state_next  = S_BSCAN;
            end
            S_BSCAN: begin
                cmd.scan = 1'b1;
                if (stat.scan_last) state_next = S_BMERGE;
            end
            S_BMERGE: begin
                cmd.merge  = 1'b1;
                state_next = S_BLRD;
            end
            S_BLRD: begin
                cmd.last_rd = 1'b1;
                state_next  = S_BMOVE;
            end
            S_BMOVE: begin
                cmd.move   = 1'b1;
                state_next = stat.last_round ? S_BROOT : S_BRST;
            end
            S_BROOT: begin
                cmd.root   = 1'b1;
                state_next = S_WRD;
            end
            S_WRD: begin
                cmd.w_rd   = 1'b1;
                state_next = S_WALK;
            end
            S_WALK: begin
                if (stat.node_leaf) begin
                    cmd.w_leaf = 1'b1;
                    state_next = stat.walk_last ? S_FIN : S_WRD;
                end else begin
                    cmd.w_left = 1'b1;
                    state_next = S_WRIGHT;
                end
            end
            S_WRIGHT: begin
                cmd.w_right = 1'b1;
                state_next  = stat.walk_last ? S_FIN : S_WRD;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ----- rtl/hcb_dpath.sv -----
// ----------------------------------------------------------------------------
// hcb_dpath
// Count, tree, code table and walk memories with the build/decode registers.
// ----------------------------------------------------------------------------
module hcb_dpath import hcb_pkg::*; #(
    parameter int SYMBOLS      = DEF_SYMBOLS,
    parameter int COUNT_BITS   = DEF_COUNT_BITS,
    parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cmd_t              cmd,
    output stat_t             stat,
    input  logic [REQ_W-1:0]  s_req,
    input  logic [BYTE_W-1:0] s_byte,
    input  logic              s_bit,
    output logic [STAT_W-1:0] m_status,
    output logic [CODE_W-1:0] m_code_bits,
    output logic [LEN_W-1:0]  m_code_length,
    output logic [BYTE_W-1:0] m_symbol,
    output logic              m_symbol_valid
);

    localparam int NODES  = 2 * SYMBOLS - 1;
    localparam int SYM_W  = $clog2(SYMBOLS);
    localparam int NODE_W = $clog2(NODES);
    localparam int CNT_W  = $clog2(SYMBOLS + 1);
    localparam int NXT_W  = $clog2(NODES + 1);
    localparam int WW     = COUNT_BITS + SYM_W;

    typedef struct packed {
        logic [NODE_W-1:0] left;
        logic [NODE_W-1:0] right;
        logic [BYTE_W-1:0] sym;
        logic              leaf;
    } node_t;

    typedef struct packed {
        logic [NODE_W-1:0] len;
        logic [CODE_W-1:0] bits;
    } walk_t;

    // memories
    logic [COUNT_BITS-1:0]   cnt_mem [SYMBOLS];
    node_t                   nd_mem  [NODES];
    walk_t                   wk_mem  [NODES];
    logic [NODE_W-1:0]       wl_mem  [SYMBOLS];
    logic [WW-1:0]           ww_mem  [SYMBOLS];
    logic [LEN_W+CODE_W-1:0] ct_mem  [SYMBOLS];

    logic [SYMBOLS-1:0]    cvalid_reg;
    logic [SYMBOLS-1:0]    present_reg;
    logic [COUNT_BITS-1:0] cnt_rd_reg;
    logic                  cv_rd_reg;
    node_t                 nd_rd_reg;
    walk_t                 wk_rd_reg;
    logic [NODE_W-1:0]     wl_rd_reg;
    logic [WW-1:0]         ww_rd_reg;
    logic [LEN_W+CODE_W-1:0] ct_rd_reg;

    logic [REQ_W-1:0]  req_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              bit_reg;
    logic [SYM_W-1:0]  s_reg, i_reg, m1_reg, m2_reg;
    logic [CNT_W-1:0]  n_reg, cnt_reg;
    logic [NXT_W-1:0]  next_reg;
    logic [WW-1:0]     w1_reg, w2_reg;
    logic [NODE_W-1:0] id1_reg, id2_reg, wi_reg, root_reg, pos_reg, child_reg;
    logic              tree_ready_reg, root_leaf_reg, empty_reg;
    logic [BYTE_W-1:0] dsym_reg;
    logic              dvalid_reg;

    logic [STAT_W-1:0] status_reg;
    logic [CODE_W-1:0] bits_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [BYTE_W-1:0] sym_reg;
    logic              valid_reg;

    logic [SYM_W-1:0]      cnt_raddr, wl_raddr, byte_idx;
    logic [NODE_W-1:0]     nd_raddr, child;
    logic                  nd_ren, wl_ren, byte_in_range;
    logic [COUNT_BITS-1:0] cnt_val;
    logic [WW-1:0]         w_cur;
    walk_t                 wk_child;

    assign byte_idx      = byte_reg[SYM_W-1:0];
    assign byte_in_range = {1'b0, byte_reg} < (BYTE_W+1)'(SYMBOLS);
    assign cnt_val       = cv_rd_reg ? cnt_rd_reg : '0;
    assign w_cur         = ww_rd_reg;
    assign child         = bit_reg ? nd_rd_reg.right : nd_rd_reg.left;
    assign wk_child.len  = wk_rd_reg.len + 1'b1;
    assign wk_child.bits = {wk_rd_reg.bits[CODE_W-2:0], cmd.w_right};

    assign stat.tree_ready = tree_ready_reg;
    assign stat.root_leaf  = root_leaf_reg;
    assign stat.leaf_last  = (s_reg == SYM_W'(SYMBOLS - 1));
    assign stat.none       = (n_reg == '0);
    assign stat.one        = (n_reg == CNT_W'(1));
    assign stat.scan_last  = (CNT_W'(i_reg) == cnt_reg - 1'b1);
    assign stat.last_round = (cnt_reg == CNT_W'(2));
    assign stat.node_leaf  = nd_rd_reg.leaf;
    assign stat.walk_last  = (wi_reg == '0);

    // read address selection
    always_comb begin
        if (cmd.load)        cnt_raddr = s_byte[SYM_W-1:0];
        else if (cmd.b_init) cnt_raddr = '0;
        else                 cnt_raddr = s_reg + 1'b1;

        nd_ren   = cmd.load || cmd.dec1 || cmd.w_rd;
        nd_raddr = cmd.dec1 ? child : (cmd.w_rd ? wi_reg : pos_reg);

        wl_ren = cmd.r_start || cmd.scan || cmd.last_rd;
        if (cmd.r_start)   wl_raddr = '0;
        else if (cmd.scan) wl_raddr = i_reg + 1'b1;
        else               wl_raddr = SYM_W'(cnt_reg - 1'b1);
    end

    // counts
    always_ff @(posedge aclk) begin
        cnt_rd_reg <= cnt_mem[cnt_raddr];
        if (cmd.cnt_wr && byte_in_range && cnt_val != {COUNT_BITS{1'b1}}) begin
            cnt_mem[byte_idx] <= cnt_val + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cvalid_reg <= '0;
        end else if (cmd.clr_cnt) begin
            cvalid_reg <= '0;
        end else if (cmd.cnt_wr && byte_in_range) begin
            cvalid_reg[byte_idx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        cv_rd_reg <= cvalid_reg[cnt_raddr];
    end

    // tree nodes: one write per cycle, leaves during the leaf sweep, merges after
    always_ff @(posedge aclk) begin
        if (cmd.leaf_step && cnt_val != '0) begin
            nd_mem[NODE_W'(n_reg)] <= '{left: '0, right: '0, sym: BYTE_W'(s_reg), leaf: 1'b1};
        end else if (cmd.merge) begin
            nd_mem[NODE_W'(next_reg)] <= '{left: id1_reg, right: id2_reg, sym: '0, leaf: 1'b0};
        end
        if (nd_ren) nd_rd_reg <= nd_mem[nd_raddr];
    end

    // working list (node id and weight side by side)
    always_ff @(posedge aclk) begin
        if (cmd.leaf_step && cnt_val != '0) begin
            wl_mem[SYM_W'(n_reg)] <= NODE_W'(n_reg);
            ww_mem[SYM_W'(n_reg)] <= WW'(cnt_val);
        end else if (cmd.merge) begin
            wl_mem[m1_reg] <= NODE_W'(next_reg);
            ww_mem[m1_reg] <= w1_reg + w2_reg;
        end else if (cmd.move) begin
            wl_mem[m2_reg] <= wl_rd_reg;
            ww_mem[m2_reg] <= ww_rd_reg;
        end
        if (wl_ren) begin
            wl_rd_reg <= wl_mem[wl_raddr];
            ww_rd_reg <= ww_mem[wl_raddr];
        end
    end

    // path codes per node
    always_ff @(posedge aclk) begin
        if (cmd.root) begin
            wk_mem[NODE_W'(next_reg - 1'b1)] <= '0;
        end else if (cmd.w_left) begin
            wk_mem[nd_rd_reg.left] <= wk_child;
        end else if (cmd.w_right) begin
            wk_mem[nd_rd_reg.right] <= wk_child;
        end
        if (cmd.w_rd) wk_rd_reg <= wk_mem[wi_reg];
    end

    // code table
    always_ff @(posedge aclk) begin
        if (cmd.w_leaf && 32'(wk_rd_reg.len) <= MAX_CODE_LEN) begin
            ct_mem[nd_rd_reg.sym[SYM_W-1:0]] <= {LEN_W'(wk_rd_reg.len), wk_rd_reg.bits};
        end
        if (cmd.load) ct_rd_reg <= ct_mem[s_byte[SYM_W-1:0]];
    end

    // control-side registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg    <= '0;
            tree_ready_reg <= 1'b0;
            root_leaf_reg  <= 1'b0;
            root_reg       <= '0;
            pos_reg        <= '0;
        end else begin
            if (cmd.b_init) present_reg <= '0;
            if (cmd.w_leaf && 32'(wk_rd_reg.len) <= MAX_CODE_LEN) begin
                present_reg[nd_rd_reg.sym[SYM_W-1:0]] <= 1'b1;
            end
            if (cmd.chk && n_reg == '0) begin
                tree_ready_reg <= 1'b0;
                root_reg       <= '0;
                pos_reg        <= '0;
            end
            if (cmd.root) begin
                tree_ready_reg <= 1'b1;
                root_leaf_reg  <= (n_reg == CNT_W'(1));
                root_reg       <= NODE_W'(next_reg - 1'b1);
                pos_reg        <= NODE_W'(next_reg - 1'b1);
            end
            if (cmd.dec2) pos_reg <= nd_rd_reg.leaf ? root_reg : child_reg;
        end
    end

    // build and decode working registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg    <= s_req;
            byte_reg   <= s_byte;
            bit_reg    <= s_bit;
            dvalid_reg <= 1'b0;
        end
        if (cmd.b_init) begin
            s_reg <= '0;
            n_reg <= '0;
        end
        if (cmd.leaf_step) begin
            s_reg <= s_reg + 1'b1;
            if (cnt_val != '0) n_reg <= n_reg + 1'b1;
        end
        if (cmd.chk) begin
            cnt_reg   <= n_reg;
            next_reg  <= NXT_W'(n_reg);
            empty_reg <= (n_reg == '0);
        end
        if (cmd.r_start) i_reg <= '0;
        if (cmd.scan) begin
            i_reg <= i_reg + 1'b1;
            if (i_reg == '0) begin
                m1_reg  <= i_reg;
                w1_reg  <= w_cur;
                id1_reg <= wl_rd_reg;
            end else if (w_cur < w1_reg) begin
                m2_reg  <= m1_reg;
                w2_reg  <= w1_reg;
                id2_reg <= id1_reg;
                m1_reg  <= i_reg;
                w1_reg  <= w_cur;
                id1_reg <= wl_rd_reg;
            end else if (i_reg == SYM_W'(1) || w_cur < w2_reg) begin
                m2_reg  <= i_reg;
                w2_reg  <= w_cur;
                id2_reg <= wl_rd_reg;
            end
        end
        if (cmd.move) begin
            cnt_reg  <= cnt_reg - 1'b1;
            next_reg <= next_reg + 1'b1;
        end
        if (cmd.root) wi_reg <= NODE_W'(next_reg - 1'b1);
        if (cmd.w_leaf || cmd.w_right) wi_reg <= wi_reg - 1'b1;
        if (cmd.dec1) child_reg <= child;
        if (cmd.dec2 && nd_rd_reg.leaf) begin
            dsym_reg   <= nd_rd_reg.sym;
            dvalid_reg <= 1'b1;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            status_reg <= ST_OK;
            bits_reg   <= '0;
            len_reg    <= '0;
            sym_reg    <= '0;
            valid_reg  <= 1'b0;
            case (req_reg)
                REQ_BUILD: status_reg <= empty_reg ? ST_EMPTY : ST_OK;
                REQ_ENCODE: begin
                    if (!tree_ready_reg) begin
                        status_reg <= ST_NOT_BUILT;
                    end else if (!byte_in_range || !present_reg[byte_idx]) begin
                        status_reg <= ST_NO_CODE;
                    end else begin
                        bits_reg <= ct_rd_reg[CODE_W-1:0];
                        len_reg  <= ct_rd_reg[LEN_W+CODE_W-1:CODE_W];
                    end
                end
                REQ_DECODE: begin
                    if (!tree_ready_reg) begin
                        status_reg <= ST_NOT_BUILT;
                    end else if (root_leaf_reg) begin
                        status_reg <= ST_SINGLE;
                    end else if (dvalid_reg) begin
                        sym_reg   <= dsym_reg;
                        valid_reg <= 1'b1;
                    end
                end
                default: status_reg <= ST_OK;
            endcase
        end
    end

    assign m_status       = status_reg;
    assign m_code_bits    = bits_reg;
    assign m_code_length  = len_reg;
    assign m_symbol       = sym_reg;
    assign m_symbol_valid = valid_reg;

endmodule
